>>> rtl/sacl_pkg.sv
// Shared types and constants of the set-associative cache LRU tag store.
// No dependencies; every other file in rtl/ imports this package.
package sacl_pkg;

   // Configuration port geometry and register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_INDEX_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE    = 2'd2;

   // Register field widths
   localparam int SET_BITS_CFG_W = 3;
   localparam int OFFSET_CFG_W   = 6;
   localparam int WAYS_CFG_W     = 4;

   // Shift amount: offset (up to 63) plus set bits (up to 7)
   localparam int SHIFT_W = 7;

   // Width of the running totals on the result channel
   localparam int TOTAL_W = 32;

   typedef struct packed {
      logic hit;
      logic miss;
      logic evict;
   } lookup_flags_type;

endpackage

>>> rtl/set_assoc_cache_lru_sim_core.sv
// Top level of the set-associative cache tag store with true LRU replacement.
// Depends on sacl_pkg, sacl_ram (tag and valid/age memories) and sacl_lookup.
//
//   Channel  Direction  Ports                       Moves
//   req      in         req_valid/req_ready         one access address per transfer
//   rsp      out        rsp_valid/rsp_ready         hit/miss/evict flags and totals
//   csr      in         csr_wr_en/csr_addr/data     one register write per enabled cycle
//
// Each access has an accept cycle that reads the set row from both memories,
// then a lookup cycle that matches tags, updates ages and writes the row back.
// After reset the valid/age memory is swept, one set per cycle, through all
// 2**MAX_SET_BITS sets before the first transfer on req is taken.
// A result waiting on rsp stalls the lookup cycle of the next access, which
// holds its read data until the result slot frees up.
module set_assoc_cache_lru_sim_core
   import sacl_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_BITS    = 64,
   parameter int COUNT_BITS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ADDR_BITS-1:0]  req_access_address,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_was_hit,
   output logic                  rsp_was_miss,
   output logic                  rsp_was_eviction,
   output logic [TOTAL_W-1:0]    rsp_hit_total,
   output logic [TOTAL_W-1:0]    rsp_miss_total,
   output logic [TOTAL_W-1:0]    rsp_eviction_total,

   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int SET_AW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NUM_SETS  = 1 << MAX_SET_BITS;
   localparam int AGE_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int META_ROW  = MAX_WAYS * (AGE_W + 1);
   localparam int TAG_ROW   = MAX_WAYS * ADDR_BITS;
   localparam logic [SET_AW-1:0] LAST_SET = SET_AW'(NUM_SETS - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   // --- control state
   logic [1:0]              state_ff, state_in;
   logic [SET_AW-1:0]       clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lookup_flags_type        rsp_flags_ff;

   // --- configuration
   logic [SET_BITS_CFG_W-1:0] set_bits_ff;
   logic [OFFSET_CFG_W-1:0]   offset_bits_ff;
   logic [WAYS_CFG_W-1:0]     ways_ff;

   // --- access in flight
   logic [ADDR_BITS-1:0]    tag_ff;
   logic [SET_AW-1:0]       set_ff;

   // --- totals
   logic [COUNT_BITS-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [COUNT_BITS-1:0]   miss_cnt_ff, miss_cnt_in;
   logic [COUNT_BITS-1:0]   evict_cnt_ff, evict_cnt_in;

   logic                    accept;
   logic                    finish;
   logic [SHIFT_W-1:0]      sbits_eff;
   logic [SHIFT_W-1:0]      tag_shift;
   logic [ADDR_BITS-1:0]    req_tag;
   logic [ADDR_BITS-1:0]    set_field;
   logic [SET_AW-1:0]       req_set;

   logic [TAG_ROW-1:0]      tag_rd, tag_wr;
   logic [META_ROW-1:0]     meta_rd, meta_new, meta_wr;
   logic                    meta_wr_en;
   logic [SET_AW-1:0]       meta_wr_addr;
   lookup_flags_type        flags;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // retire the lookup only when the result slot is free or being drained
   assign finish    = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);

   // --- address split: set bits saturate at MAX_SET_BITS, overlong shifts read zero
   assign sbits_eff = (int'(set_bits_ff) > MAX_SET_BITS) ? SHIFT_W'(MAX_SET_BITS)
                                                         : SHIFT_W'(set_bits_ff);
   assign tag_shift = sbits_eff + SHIFT_W'(offset_bits_ff);
   assign req_tag   = req_access_address >> tag_shift;
   assign set_field = (req_access_address >> offset_bits_ff) &
                      ~({ADDR_BITS{1'b1}} << sbits_eff);
   assign req_set   = set_field[SET_AW-1:0];

   // --- sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // --- configuration writes; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= '0;
         offset_bits_ff <= '0;
         ways_ff        <= WAYS_CFG_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_SET_INDEX_BITS: set_bits_ff    <= csr_wr_data[SET_BITS_CFG_W-1:0];
            CSR_OFFSET_BITS:    offset_bits_ff <= csr_wr_data[OFFSET_CFG_W-1:0];
            CSR_WAYS_IN_USE:    ways_ff        <= csr_wr_data[WAYS_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // --- capture tag and set of the accepted access
   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff <= req_tag;
         set_ff <= req_set;
      end
   end

   // --- memories: tags are never cleared, valid/age rows are swept after reset
   assign meta_wr_en   = (state_ff == ST_CLEAR) || finish;
   assign meta_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : set_ff;
   assign meta_wr      = (state_ff == ST_CLEAR) ? '0 : meta_new;

   sacl_ram #(
      .WIDTH  (TAG_ROW),
      .DEPTH  (NUM_SETS),
      .ADDR_W (SET_AW)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (finish),
      .wr_addr (set_ff),
      .wr_data (tag_wr),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (tag_rd)
   );

   sacl_ram #(
      .WIDTH  (META_ROW),
      .DEPTH  (NUM_SETS),
      .ADDR_W (SET_AW)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (meta_rd)
   );

   sacl_lookup #(
      .MAX_WAYS  (MAX_WAYS),
      .ADDR_BITS (ADDR_BITS),
      .AGE_W     (AGE_W)
   ) u_lookup (
      .ways_cfg     (ways_ff),
      .tag          (tag_ff),
      .tag_row      (tag_rd),
      .meta_row     (meta_rd),
      .new_tag_row  (tag_wr),
      .new_meta_row (meta_new),
      .flags        (flags)
   );

   // --- saturating totals, advanced when the lookup retires
   always_comb begin
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      if (finish) begin
         if (flags.hit && (hit_cnt_ff != '1)) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
         end
         if (flags.miss && (miss_cnt_ff != '1)) begin
            miss_cnt_in = miss_cnt_ff + 1'b1;
         end
         if (flags.evict && (evict_cnt_ff != '1)) begin
            evict_cnt_in = evict_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
      end else begin
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         evict_cnt_ff <= evict_cnt_in;
      end
   end

   // --- result register; totals only move when a new result loads
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_flags_ff <= flags;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_was_hit        = rsp_flags_ff.hit;
   assign rsp_was_miss       = rsp_flags_ff.miss;
   assign rsp_was_eviction   = rsp_flags_ff.evict;
   assign rsp_hit_total      = TOTAL_W'({{TOTAL_W{1'b0}}, hit_cnt_ff});
   assign rsp_miss_total     = TOTAL_W'({{TOTAL_W{1'b0}}, miss_cnt_ff});
   assign rsp_eviction_total = TOTAL_W'({{TOTAL_W{1'b0}}, evict_cnt_ff});

endmodule

>>> rtl/sacl_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing outside this file beyond the package import.
module sacl_ram
   import sacl_pkg::*;
#(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sacl_lookup.sv
// Way logic for one set: tag match, fill/victim choice and LRU age update.
// Depends on sacl_pkg for the flag struct and the ways register width.
module sacl_lookup
   import sacl_pkg::*;
#(
   parameter int MAX_WAYS  = 8,
   parameter int ADDR_BITS = 64,
   parameter int AGE_W     = 3
) (
   input  logic [WAYS_CFG_W-1:0]            ways_cfg,
   input  logic [ADDR_BITS-1:0]             tag,
   input  logic [MAX_WAYS*ADDR_BITS-1:0]    tag_row,
   input  logic [MAX_WAYS*(AGE_W+1)-1:0]    meta_row,
   output logic [MAX_WAYS*ADDR_BITS-1:0]    new_tag_row,
   output logic [MAX_WAYS*(AGE_W+1)-1:0]    new_meta_row,
   output lookup_flags_type                 flags
);

   localparam int WAY_IW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int META_W = AGE_W + 1;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] valid;
   logic [MAX_WAYS-1:0] match;
   logic [MAX_WAYS-1:0] empty;
   logic [AGE_W-1:0]    age [MAX_WAYS];

   logic [WAY_IW-1:0]   hit_way;
   logic [WAY_IW-1:0]   empty_way;
   logic [WAY_IW-1:0]   victim_way;
   logic [WAY_IW-1:0]   way_sel;
   logic                hit;
   logic                found_empty;
   logic                was_valid;
   logic [AGE_W-1:0]    old_age;

   // unpack the set; way 0 is always in use, zero ways acts as one
   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         valid[i]  = meta_row[i*META_W + AGE_W];
         age[i]    = meta_row[i*META_W +: AGE_W];
         in_use[i] = (i == 0) || (int'(ways_cfg) > i);
         match[i]  = in_use[i] && valid[i] &&
                     (tag_row[i*ADDR_BITS +: ADDR_BITS] == tag);
         empty[i]  = in_use[i] && !valid[i];
      end
   end

   // lowest matching way, lowest empty way, oldest way (lowest on a tie)
   always_comb begin
      hit_way    = '0;
      empty_way  = '0;
      victim_way = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_way = WAY_IW'(i);
         end
         if (empty[i]) begin
            empty_way = WAY_IW'(i);
         end
      end
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (in_use[i] && (age[i] > age[victim_way])) begin
            victim_way = WAY_IW'(i);
         end
      end
   end

   assign hit         = |match;
   assign found_empty = |empty;
   assign was_valid   = hit || !found_empty;
   assign way_sel     = hit ? hit_way : (found_empty ? empty_way : victim_way);
   assign old_age     = age[way_sel];

   // chosen way is newest; valid in-use ways age +1 if younger or on a fill
   always_comb begin
      new_tag_row  = tag_row;
      new_meta_row = meta_row;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAY_IW'(i) == way_sel) begin
            new_tag_row[i*ADDR_BITS +: ADDR_BITS] = tag;
            new_meta_row[i*META_W + AGE_W]        = 1'b1;
            new_meta_row[i*META_W +: AGE_W]       = '0;
         end else if (in_use[i] && valid[i] && (!was_valid || (age[i] < old_age)) &&
                      (age[i] < AGE_MAX)) begin
            new_meta_row[i*META_W +: AGE_W] = age[i] + 1'b1;
         end
      end
   end

   assign flags.hit   = hit;
   assign flags.miss  = !hit;
   assign flags.evict = !hit && !found_empty;

endmodule
